// ----- rtl/assert_macros.svh -----
// assertion macros for the lexer rtl
// no dependencies; included inside module bodies that assert
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/jscl_pkg.sv -----
// types and constants of the json subset character lexer
// no dependencies; imported by the lexer top, classifier, checker and testbench
package jscl_pkg;

    // character codes
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_UC_A   = 8'h41;
    localparam logic [7:0] CH_UC_Z   = 8'h5A;
    localparam logic [7:0] CH_LC_A   = 8'h61;
    localparam logic [7:0] CH_LC_Z   = 8'h7A;

    // token kinds
    localparam logic [3:0] KIND_NUMBER    = 4'd0;
    localparam logic [3:0] KIND_STRING    = 4'd1;
    localparam logic [3:0] KIND_COMMA     = 4'd2;
    localparam logic [3:0] KIND_OBJ_BEGIN = 4'd3;
    localparam logic [3:0] KIND_OBJ_END   = 4'd4;
    localparam logic [3:0] KIND_ARR_BEGIN = 4'd5;
    localparam logic [3:0] KIND_ARR_END   = 4'd6;
    localparam logic [3:0] KIND_COLON     = 4'd7;
    localparam logic [3:0] KIND_END       = 4'd8;

    // status codes
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_BAD_NUM  = 2'd1;
    localparam logic [1:0] STAT_BAD_CHAR = 2'd2;
    localparam logic [1:0] STAT_OVERFLOW = 2'd3;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_NUM  = 2'd1,
        MODE_STR  = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        S_ACC,   // take input characters
        S_RD,    // read one buffered character
        S_WR,    // hand the read character to the output register
        S_SYM    // hand the closing symbol to the output register
    } t_state;

    // character class from the decoder
    typedef struct packed {
        logic       is_digit;
        logic       is_space;
        logic       is_quote;
        logic       is_str;
        logic       is_sym;
        logic       is_closer;  // comma, ] or }
        logic [3:0] sym_kind;
    } t_char_class;

    // one result beat
    typedef struct packed {
        logic       last;
        logic [1:0] status;
        logic       char_valid;
        logic [7:0] data_char;
        logic [3:0] token_kind;
    } t_result;

endpackage

// ----- rtl/jscl_ram.sv -----
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module jscl_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 32,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read, holds while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/jscl_classify.sv -----
// character class decoder of the lexer
// depends on jscl_pkg
module jscl_classify (
    input  logic                   [7:0] i_char,
    output jscl_pkg::t_char_class        o_class
);
    import jscl_pkg::*;

    logic is_digit;
    logic is_space;
    logic is_alpha;

    assign is_digit = (i_char >= CH_ZERO) && (i_char <= CH_NINE);
    assign is_space = (i_char == CH_SPACE) || (i_char == CH_TAB);
    assign is_alpha = ((i_char >= CH_LC_A) && (i_char <= CH_LC_Z)) ||
                      ((i_char >= CH_UC_A) && (i_char <= CH_UC_Z));

    // symbol lookup
    always_comb begin
        o_class           = '0;
        o_class.is_digit  = is_digit;
        o_class.is_space  = is_space;
        o_class.is_quote  = (i_char == CH_QUOTE);
        o_class.is_str    = is_alpha || is_digit || is_space;
        o_class.is_sym    = 1'b1;
        o_class.sym_kind  = KIND_NUMBER;
        unique case (i_char)
            CH_COMMA: begin
                o_class.sym_kind  = KIND_COMMA;
                o_class.is_closer = 1'b1;
            end
            CH_LBRACE: o_class.sym_kind = KIND_OBJ_BEGIN;
            CH_RBRACE: begin
                o_class.sym_kind  = KIND_OBJ_END;
                o_class.is_closer = 1'b1;
            end
            CH_LBRACK: o_class.sym_kind = KIND_ARR_BEGIN;
            CH_RBRACK: begin
                o_class.sym_kind  = KIND_ARR_END;
                o_class.is_closer = 1'b1;
            end
            CH_COLON: o_class.sym_kind = KIND_COLON;
            default:  o_class.is_sym = 1'b0;
        endcase
    end

endmodule

// ----- rtl/json_subset_char_lexer_unit.sv -----
// top level of the json subset character lexer
// depends on jscl_pkg, jscl_classify, jscl_ram and assert_macros.svh
//
// channel   dir  beat fields (tdata low bit first)
// s_axis    in   tdata: char_code[7:0]; tlast: end_of_stream
// m_axis    out  tdata: token_kind[3:0], data_char[11:4], char_valid[12],
//                status[14:13], zero[15]; tlast: last
//
// a character that gives at most one result loads it straight into the output register.
// a finished number or string is read back from the token ram one buffered
// character at a time (ram read, then output load once the output is free),
// then a closing symbol if one is pending; the ram has a single read port.
// the token ram has no reset and no clearing pass; mode and fill count reset.
// input is taken only in S_ACC while the output register is empty or being drained.
module json_subset_char_lexer_unit #(
    parameter int MAX_TOKEN_LEN = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // char_code[7:0]
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // token_kind, data_char, char_valid, status, pad
    output logic        m_axis_tlast
);
    import jscl_pkg::*;

    localparam int AW = (MAX_TOKEN_LEN > 1) ? $clog2(MAX_TOKEN_LEN) : 1;
    localparam int FW = $clog2(MAX_TOKEN_LEN + 1);
    localparam logic [FW-1:0] FILL_MAX = FW'(MAX_TOKEN_LEN);

    t_state      r_state, n_state;
    t_mode       r_mode, n_mode;
    logic [FW-1:0] r_fill, n_fill;
    logic [FW-1:0] r_idx, n_idx;
    logic [FW-1:0] idx_inc;
    logic [3:0]  r_kind, n_kind;
    logic [3:0]  r_sym, n_sym;
    logic        r_sym_pend, n_sym_pend;
    logic        r_m_valid, n_m_valid;
    t_result     r_m_res, n_m_res;

    t_char_class cls;
    logic        in_beat;
    logic        out_free;
    logic        full;
    logic        ram_we;
    logic        ram_re;
    logic [7:0]  ram_rdata;

    jscl_classify u_classify (
        .i_char  (s_axis_tdata),
        .o_class (cls)
    );

    jscl_ram #(
        .WIDTH (8),
        .DEPTH (MAX_TOKEN_LEN)
    ) u_buf_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_fill[AW-1:0]),
        .i_wdata (s_axis_tdata),
        .i_re    (ram_re),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    assign out_free      = !r_m_valid || m_axis_tready;
    assign s_axis_tready = (r_state == S_ACC) && out_free;
    assign in_beat       = s_axis_tvalid && s_axis_tready;
    assign full          = (r_fill >= FILL_MAX);
    assign idx_inc       = FW'(r_idx + 1'b1);

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_ACC;
            r_mode    <= MODE_IDLE;
            r_fill    <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_mode    <= n_mode;
            r_fill    <= n_fill;
            r_m_valid <= n_m_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_kind     <= n_kind;
        r_sym      <= n_sym;
        r_sym_pend <= n_sym_pend;
        r_m_res    <= n_m_res;
    end

    // next state, buffer access and result loading
    always_comb begin
        n_state    = r_state;
        n_mode     = r_mode;
        n_fill     = r_fill;
        n_idx      = r_idx;
        n_kind     = r_kind;
        n_sym      = r_sym;
        n_sym_pend = r_sym_pend;
        n_m_valid  = r_m_valid && !m_axis_tready;
        n_m_res    = r_m_res;
        ram_we     = 1'b0;
        ram_re     = 1'b0;

        unique case (r_state)
            S_ACC: begin
                if (in_beat) begin
                    n_m_res = '{last: 1'b1, status: STAT_OK, char_valid: 1'b0,
                                data_char: 8'd0, token_kind: KIND_NUMBER};
                    if (s_axis_tlast) begin
                        // end of stream drops any open token
                        n_mode     = MODE_IDLE;
                        n_fill     = '0;
                        n_m_valid  = 1'b1;
                        n_m_res.token_kind = KIND_END;
                    end else begin
                        unique case (r_mode)
                            MODE_NUM: begin
                                if (cls.is_digit) begin
                                    if (full) begin
                                        n_m_valid      = 1'b1;
                                        n_m_res.status = STAT_OVERFLOW;
                                    end else begin
                                        ram_we = 1'b1;
                                        n_fill = FW'(r_fill + 1'b1);
                                    end
                                end else if (cls.is_space || cls.is_closer) begin
                                    // number ends; read it back, then any closer
                                    n_mode     = MODE_IDLE;
                                    n_state    = S_RD;
                                    n_idx      = '0;
                                    n_kind     = KIND_NUMBER;
                                    n_sym      = cls.sym_kind;
                                    n_sym_pend = cls.is_closer;
                                end else begin
                                    n_m_valid      = 1'b1;
                                    n_m_res.status = STAT_BAD_NUM;
                                end
                            end
                            MODE_STR: begin
                                if (cls.is_quote) begin
                                    n_mode = MODE_IDLE;
                                    if (r_fill == '0) begin
                                        // empty string
                                        n_m_valid          = 1'b1;
                                        n_m_res.token_kind = KIND_STRING;
                                    end else begin
                                        n_state    = S_RD;
                                        n_idx      = '0;
                                        n_kind     = KIND_STRING;
                                        n_sym_pend = 1'b0;
                                    end
                                end else if (cls.is_str) begin
                                    if (full) begin
                                        n_m_valid      = 1'b1;
                                        n_m_res.status = STAT_OVERFLOW;
                                    end else begin
                                        ram_we = 1'b1;
                                        n_fill = FW'(r_fill + 1'b1);
                                    end
                                end else begin
                                    n_m_valid      = 1'b1;
                                    n_m_res.status = STAT_BAD_CHAR;
                                end
                            end
                            default: begin
                                // idle, and the unused mode code
                                priority if (cls.is_quote) begin
                                    n_mode = MODE_STR;
                                    n_fill = '0;
                                end else if (cls.is_digit) begin
                                    n_mode = MODE_NUM;
                                    n_fill = FW'(1);
                                    ram_we = 1'b1;
                                end else if (cls.is_space) begin
                                    n_mode = r_mode;
                                end else if (cls.is_sym) begin
                                    n_m_valid          = 1'b1;
                                    n_m_res.token_kind = cls.sym_kind;
                                end else begin
                                    n_m_valid      = 1'b1;
                                    n_m_res.status = STAT_BAD_CHAR;
                                end
                            end
                        endcase
                    end
                end
            end
            S_RD: begin
                ram_re  = 1'b1;
                n_state = S_WR;
            end
            S_WR: begin
                if (out_free) begin
                    n_m_valid = 1'b1;
                    n_m_res   = '{last: (idx_inc == r_fill) && !r_sym_pend,
                                  status: STAT_OK, char_valid: 1'b1,
                                  data_char: ram_rdata, token_kind: r_kind};
                    n_idx     = idx_inc;
                    if (idx_inc == r_fill) begin
                        n_fill  = '0;
                        n_state = r_sym_pend ? S_SYM : S_ACC;
                    end else begin
                        n_state = S_RD;
                    end
                end
            end
            S_SYM: begin
                if (out_free) begin
                    n_m_valid = 1'b1;
                    n_m_res   = '{last: 1'b1, status: STAT_OK, char_valid: 1'b0,
                                  data_char: 8'd0, token_kind: r_sym};
                    n_state   = S_ACC;
                end
            end
            default: n_state = S_ACC;
        endcase
    end

    // output register
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {1'b0, r_m_res.status, r_m_res.char_valid,
                            r_m_res.data_char, r_m_res.token_kind};
    assign m_axis_tlast  = r_m_res.last;

    // checks
    `include "assert_macros.svh"

    `ASSERT_SAME(a_fill_bound, i_clk, i_rst_n, 1'b1, r_fill <= FILL_MAX, "fill count beyond buffer")
    `ASSERT_SAME(a_read_in_range, i_clk, i_rst_n, r_state == S_WR, r_idx < r_fill, "read index past fill")
    `ASSERT_NEXT(a_read_then_load, i_clk, i_rst_n, r_state == S_RD, r_state == S_WR, "ram read not followed by load")
    `ASSERT_NEXT(a_run_idle_mode, i_clk, i_rst_n, r_state == S_ACC && n_state == S_RD, r_mode == MODE_IDLE, "mode open during run")

endmodule

// ----- test/json_subset_char_lexer_checker.sv -----
`timescale 1ns / 1ps
// checker for the json subset character lexer: predicts the token beats of
// every accepted character and compares them with the output stream
// depends on jscl_pkg
module json_subset_char_lexer_checker #(
    parameter int MAX_TOKEN_LEN = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // char_code[7:0]
    input  logic        s_axis_tlast,   // end_of_stream
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [15:0] m_axis_tdata,   // token_kind, data_char, char_valid, status, pad
    input  logic        m_axis_tlast,   // last
    output int          o_mismatch_count,
    output int          o_beats_pending
);
    import jscl_pkg::*;

    localparam int REPORT_LIMIT = 10;

    // lexer state as predicted
    t_mode       scan_mode;
    int unsigned held_count;
    logic [7:0]  token_chars [MAX_TOKEN_LEN];

    // token beats still to come, and the beats of the character being lexed
    t_result     token_beats_q [$];
    t_result     item_beats [$];
    int          mismatch_total = 0;

    function automatic bit is_numeral(input logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic bit is_blank(input logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB;
    endfunction

    function automatic bit is_text(input logic [7:0] c);
        return (c >= CH_LC_A && c <= CH_LC_Z) || (c >= CH_UC_A && c <= CH_UC_Z) ||
               is_numeral(c) || is_blank(c);
    endfunction

    function automatic bit decode_symbol(input logic [7:0] c, output logic [3:0] kind);
        kind = KIND_NUMBER;
        case (c)
            CH_COMMA:  kind = KIND_COMMA;
            CH_LBRACE: kind = KIND_OBJ_BEGIN;
            CH_RBRACE: kind = KIND_OBJ_END;
            CH_LBRACK: kind = KIND_ARR_BEGIN;
            CH_RBRACK: kind = KIND_ARR_END;
            CH_COLON:  kind = KIND_COLON;
            default:   return 1'b0;
        endcase
        return 1'b1;
    endfunction

    function automatic void queue_beat(input logic [3:0] kind, input logic [7:0] ch,
                                       input logic valid, input logic [1:0] status);
        t_result r;
        r            = '0;
        r.token_kind = kind;
        r.data_char  = ch;
        r.char_valid = valid;
        r.status     = status;
        item_beats.push_back(r);
    endfunction

    // a full buffer drops the character and flags overflow
    function automatic void buffer_char(input logic [7:0] c);
        if (held_count < MAX_TOKEN_LEN) begin
            token_chars[held_count] = c;
            held_count++;
        end else begin
            queue_beat(KIND_NUMBER, 8'h00, 1'b0, STAT_OVERFLOW);
        end
    endfunction

    // buffered characters go out one per beat; an empty token gives one bare beat
    function automatic void flush_token(input logic [3:0] kind);
        if (held_count == 0) begin
            queue_beat(kind, 8'h00, 1'b0, STAT_OK);
        end else begin
            for (int i = 0; i < held_count; i++)
                queue_beat(kind, token_chars[i], 1'b1, STAT_OK);
        end
        held_count = 0;
        scan_mode  = MODE_IDLE;
    endfunction

    function automatic void lex_char(input logic [7:0] c, input logic eos);
        logic [3:0] sym;
        bit         is_sym;
        t_result    tail;
        item_beats.delete();
        is_sym = decode_symbol(c, sym);
        if (eos) begin
            // a pending token is dropped
            scan_mode  = MODE_IDLE;
            held_count = 0;
            queue_beat(KIND_END, 8'h00, 1'b0, STAT_OK);
        end else begin
            case (scan_mode)
                MODE_NUM: begin
                    if (is_numeral(c)) begin
                        buffer_char(c);
                    end else if (is_blank(c)) begin
                        flush_token(KIND_NUMBER);
                    end else if (is_sym && (sym == KIND_COMMA || sym == KIND_OBJ_END ||
                                            sym == KIND_ARR_END)) begin
                        flush_token(KIND_NUMBER);
                        queue_beat(sym, 8'h00, 1'b0, STAT_OK);
                    end else begin
                        queue_beat(KIND_NUMBER, 8'h00, 1'b0, STAT_BAD_NUM);
                    end
                end
                MODE_STR: begin
                    if (c == CH_QUOTE) begin
                        flush_token(KIND_STRING);
                    end else if (is_text(c)) begin
                        buffer_char(c);
                    end else begin
                        queue_beat(KIND_NUMBER, 8'h00, 1'b0, STAT_BAD_CHAR);
                    end
                end
                // idle, and the unused mode code behaves the same
                default: begin
                    if (c == CH_QUOTE) begin
                        scan_mode  = MODE_STR;
                        held_count = 0;
                    end else if (is_numeral(c)) begin
                        scan_mode  = MODE_NUM;
                        held_count = 0;
                        buffer_char(c);
                    end else if (is_blank(c)) begin
                        // whitespace between tokens is dropped
                    end else if (is_sym) begin
                        queue_beat(sym, 8'h00, 1'b0, STAT_OK);
                    end else begin
                        queue_beat(KIND_NUMBER, 8'h00, 1'b0, STAT_BAD_CHAR);
                    end
                end
            endcase
        end
        // mark the final beat of this character
        if (item_beats.size() > 0) begin
            tail      = item_beats.pop_back();
            tail.last = 1'b1;
            item_beats.push_back(tail);
        end
        foreach (item_beats[i])
            token_beats_q.push_back(item_beats[i]);
    endfunction

    // output beats are checked before the new character is lexed: a beat
    // taken at this edge can only belong to an earlier character
    always @(posedge i_clk) begin : monitor
        t_result seen;
        t_result want;
        if (!i_rst_n) begin
            scan_mode  = MODE_IDLE;
            held_count = 0;
            token_beats_q.delete();
            o_beats_pending  <= 0;
            o_mismatch_count <= mismatch_total;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                seen.token_kind = m_axis_tdata[3:0];
                seen.data_char  = m_axis_tdata[11:4];
                seen.char_valid = m_axis_tdata[12];
                seen.status     = m_axis_tdata[14:13];
                seen.last       = m_axis_tlast;
                if (token_beats_q.size() == 0) begin
                    if (mismatch_total < REPORT_LIMIT)
                        $display("%0t: beat with nothing expected: kind %0d char %02h valid %0b",
                                 $time, seen.token_kind, seen.data_char, seen.char_valid,
                                 " status %0d last %0b", seen.status, seen.last);
                    mismatch_total++;
                end else begin
                    want = token_beats_q.pop_front();
                    if (seen.token_kind !== want.token_kind || seen.data_char !== want.data_char ||
                        seen.char_valid !== want.char_valid || seen.status !== want.status ||
                        seen.last !== want.last) begin
                        if (mismatch_total < REPORT_LIMIT)
                            $display("%0t: beat mismatch: expected kind %0d char %02h valid %0b",
                                     $time, want.token_kind, want.data_char, want.char_valid,
                                     " status %0d last %0b", want.status, want.last,
                                     "; got kind %0d char %02h valid %0b",
                                     seen.token_kind, seen.data_char, seen.char_valid,
                                     " status %0d last %0b", seen.status, seen.last);
                        mismatch_total++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                lex_char(s_axis_tdata, s_axis_tlast);
            o_beats_pending  <= token_beats_q.size();
            o_mismatch_count <= mismatch_total;
        end
    end

endmodule

// ----- test/tb_json_subset_char_lexer_unit.sv -----
`timescale 1ns / 1ps
// testbench top for the json subset character lexer: drives directed and random
// character streams with random stalls on both sides and gives the verdict
// depends on jscl_pkg, json_subset_char_lexer_unit and json_subset_char_lexer_checker
module tb_json_subset_char_lexer_unit;

    import jscl_pkg::*;

    localparam int TOKEN_LEN     = 32;
    localparam int RANDOM_ITEMS  = 410;
    localparam int SETTLE_CYCLES = 150;
    localparam int CYCLE_LIMIT   = 2000000;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'h00;   // char_code[7:0]
    logic        s_axis_tlast  = 1'b0;    // end_of_stream
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b1;
    logic [15:0] m_axis_tdata;            // token_kind, data_char, char_valid, status, pad
    logic        m_axis_tlast;            // last

    int          mismatch_count;
    int          beats_pending;
    int          item_count   = 0;
    int          source_burst = 0;
    int          sink_burst   = 0;
    int          sink_stall   = 0;
    int          cycle_count  = 0;

    json_subset_char_lexer_unit #(
        .MAX_TOKEN_LEN (TOKEN_LEN)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    json_subset_char_lexer_checker #(
        .MAX_TOKEN_LEN (TOKEN_LEN)
    ) u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .s_axis_tvalid    (s_axis_tvalid),
        .s_axis_tready    (s_axis_tready),
        .s_axis_tdata     (s_axis_tdata),
        .s_axis_tlast     (s_axis_tlast),
        .m_axis_tvalid    (m_axis_tvalid),
        .m_axis_tready    (m_axis_tready),
        .m_axis_tdata     (m_axis_tdata),
        .m_axis_tlast     (m_axis_tlast),
        .o_mismatch_count (mismatch_count),
        .o_beats_pending  (beats_pending)
    );

    // 4 ns clock
    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // idle cycles per beat, with stretches of back-to-back beats
    function automatic int draw_gap(inout int burst_left);
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        if ($urandom_range(0, 9) == 0) begin
            burst_left = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, 18);
    endfunction

    // output side: stall a random number of cycles after each taken beat
    always @(posedge i_clk) begin
        if (m_axis_tvalid && m_axis_tready) begin
            sink_stall = draw_gap(sink_burst);
            m_axis_tready <= (sink_stall == 0);
        end else if (sink_stall > 0) begin
            sink_stall--;
            m_axis_tready <= (sink_stall == 0);
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic logic [7:0] blank_char();
        return ($urandom_range(0, 1) == 0) ? CH_SPACE : CH_TAB;
    endfunction

    function automatic logic [7:0] digit_char();
        return CH_ZERO + 8'($urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] text_char();
        case ($urandom_range(0, 3))
            0:       return CH_LC_A + 8'($urandom_range(0, 25));
            1:       return CH_UC_A + 8'($urandom_range(0, 25));
            2:       return digit_char();
            default: return blank_char();
        endcase
    endfunction

    // a byte that neither extends nor ends a number
    function automatic logic [7:0] bad_number_char();
        logic [7:0] c;
        if ($urandom_range(0, 3) == 0)
            return CH_QUOTE;
        do
            c = 8'($urandom_range(0, 255));
        while ((c >= CH_ZERO && c <= CH_NINE) || c == CH_SPACE || c == CH_TAB ||
               c == CH_COMMA || c == CH_RBRACK || c == CH_RBRACE);
        return c;
    endfunction

    // a byte not allowed inside a string
    function automatic logic [7:0] bad_text_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while ((c >= CH_LC_A && c <= CH_LC_Z) || (c >= CH_UC_A && c <= CH_UC_Z) ||
               (c >= CH_ZERO && c <= CH_NINE) || c == CH_SPACE || c == CH_TAB ||
               c == CH_QUOTE);
        return c;
    endfunction

    // mostly short tokens, now and then past the buffer size
    function automatic int token_len();
        if ($urandom_range(0, 11) == 0)
            return $urandom_range(TOKEN_LEN - 3, TOKEN_LEN + 4);
        return $urandom_range(1, 6);
    endfunction

    // one input beat; called and returns at a rising edge
    task automatic send_beat(input logic [7:0] c, input logic eos);
        int gap;
        gap = draw_gap(source_burst);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tlast  <= eos;
        // ready is settled by the falling edge
        @(negedge i_clk);
        while (!s_axis_tready) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic send_counted(input logic [7:0] c, input logic eos);
        send_beat(c, eos);
        item_count++;
    endtask

    // hold the input until every predicted beat has come out
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
        while (beats_pending != 0) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    initial begin : stimulus
        int len;
        bit drained_mid;
        drained_mid = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // byte extremes and each symbol from idle
        send_beat(8'h00, 1'b0);
        send_beat(8'hFF, 1'b0);
        send_beat(CH_LBRACE, 1'b0);
        send_beat(CH_RBRACE, 1'b0);
        send_beat(CH_LBRACK, 1'b0);
        send_beat(CH_RBRACK, 1'b0);
        send_beat(CH_COLON, 1'b0);
        send_beat(CH_COMMA, 1'b0);
        // whitespace between tokens
        send_beat(CH_SPACE, 1'b0);
        send_beat(CH_TAB, 1'b0);
        // number with a quote and a letter inside, closed by ]
        send_beat(CH_ZERO, 1'b0);
        send_beat(CH_NINE, 1'b0);
        send_beat(CH_QUOTE, 1'b0);
        send_beat(CH_LC_A, 1'b0);
        send_beat(CH_RBRACK, 1'b0);
        // number closed by a space
        send_beat(CH_ZERO + 8'd7, 1'b0);
        send_beat(CH_SPACE, 1'b0);
        // empty string
        send_beat(CH_QUOTE, 1'b0);
        send_beat(CH_QUOTE, 1'b0);
        // string with a tab and a bad byte inside
        send_beat(CH_QUOTE, 1'b0);
        send_beat(CH_UC_Z, 1'b0);
        send_beat(CH_TAB, 1'b0);
        send_beat(8'h21, 1'b0);
        send_beat(CH_QUOTE, 1'b0);
        // open number dropped by end of stream
        send_beat(CH_ZERO + 8'd5, 1'b0);
        send_beat(8'hFF, 1'b1);
        wait_drained();

        // overflow of a number and of a string
        repeat (TOKEN_LEN + 2) send_counted(digit_char(), 1'b0);
        send_counted(CH_COMMA, 1'b0);
        send_counted(CH_QUOTE, 1'b0);
        repeat (TOKEN_LEN + 2) send_counted(text_char(), 1'b0);
        send_counted(CH_QUOTE, 1'b0);

        // random token streams
        while (item_count < RANDOM_ITEMS) begin
            if (!drained_mid && item_count >= RANDOM_ITEMS / 2) begin
                wait_drained();
                drained_mid = 1'b1;
            end
            case ($urandom_range(0, 11))
                // number, sometimes with a bad byte inside
                0, 1, 2, 3: begin
                    len = token_len();
                    send_counted(digit_char(), 1'b0);
                    for (int i = 1; i < len; i++) begin
                        if ($urandom_range(0, 15) == 0)
                            send_counted(bad_number_char(), 1'b0);
                        send_counted(digit_char(), 1'b0);
                    end
                    case ($urandom_range(0, 5))
                        0, 1:    send_counted(blank_char(), 1'b0);
                        2:       send_counted(CH_COMMA, 1'b0);
                        3:       send_counted(CH_RBRACK, 1'b0);
                        4:       send_counted(CH_RBRACE, 1'b0);
                        default: send_counted(8'($urandom_range(0, 255)), 1'b1);
                    endcase
                end
                // string, sometimes empty, sometimes cut by end of stream
                4, 5, 6: begin
                    len = ($urandom_range(0, 4) == 0) ? 0 : token_len();
                    send_counted(CH_QUOTE, 1'b0);
                    repeat (len) begin
                        if ($urandom_range(0, 15) == 0)
                            send_counted(bad_text_char(), 1'b0);
                        send_counted(text_char(), 1'b0);
                    end
                    if ($urandom_range(0, 11) == 0)
                        send_counted(8'($urandom_range(0, 255)), 1'b1);
                    else
                        send_counted(CH_QUOTE, 1'b0);
                end
                // structural symbol
                7, 8, 9: begin
                    case ($urandom_range(0, 5))
                        0:       send_counted(CH_LBRACE, 1'b0);
                        1:       send_counted(CH_RBRACE, 1'b0);
                        2:       send_counted(CH_LBRACK, 1'b0);
                        3:       send_counted(CH_RBRACK, 1'b0);
                        4:       send_counted(CH_COLON, 1'b0);
                        default: send_counted(CH_COMMA, 1'b0);
                    endcase
                end
                // any byte
                10: send_counted(8'($urandom_range(0, 255)), 1'b0);
                // end of stream with any byte beside it
                default: send_counted(8'($urandom_range(0, 255)), 1'b1);
            endcase
            if ($urandom_range(0, 3) == 0)
                send_beat(blank_char(), 1'b0);
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
